// ===== hw/rtl/morse_character_keyer_defines.svh =====
// ---------------------------------------------------------------------------
// Morse character keyer assertion macros
// Shared concurrent assertion helpers for the keyer RTL.
// ---------------------------------------------------------------------------
`ifndef MORSE_CHARACTER_KEYER_DEFINES_SVH
`define MORSE_CHARACTER_KEYER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define MCK_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define MCK_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MCK_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MCK_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/mck_pkg.sv =====
// ---------------------------------------------------------------------------
// Morse character keyer package
// Types, constants and the character code table shared by the keyer.
// ---------------------------------------------------------------------------
package mck_pkg;

  // Default depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Segment lengths in Morse time units.
  localparam logic [1:0] GAP_UNITS   = 2'd1;
  localparam logic [1:0] DOT_UNITS   = 2'd1;
  localparam logic [1:0] DASH_UNITS  = 2'd3;
  localparam logic [1:0] SPACE_UNITS = 2'd3;

  // Number of characters with a Morse code (a..z, then 0..9).
  localparam int NUM_CODES = 36;

  // One classified character as it waits in the queue.
  // dash_mask bit i is 1 when symbol i is a dash; symbol 0 is sent first.
  typedef struct packed {
    logic       known;
    logic [2:0] sym_count;
    logic [4:0] dash_mask;
  } code_entry_t;

  // Queue fill status seen by both neighbors.
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  // Sequencer status for checking.
  typedef struct packed {
    logic       busy;
    logic [3:0] step;
  } back_status_t;

  // Code table, each entry {sym_count, dash_mask}.
  localparam logic [7:0] CODE_ROM [NUM_CODES] = '{
    {3'd2, 5'b00010}, {3'd4, 5'b00001}, {3'd4, 5'b00101}, {3'd3, 5'b00001},
    {3'd1, 5'b00000}, {3'd4, 5'b00100}, {3'd3, 5'b00011}, {3'd4, 5'b00000},
    {3'd2, 5'b00000}, {3'd4, 5'b01110}, {3'd3, 5'b00101}, {3'd4, 5'b00010},
    {3'd2, 5'b00011}, {3'd2, 5'b00001}, {3'd3, 5'b00111}, {3'd4, 5'b00110},
    {3'd4, 5'b01011}, {3'd3, 5'b00010}, {3'd3, 5'b00000}, {3'd1, 5'b00001},
    {3'd3, 5'b00100}, {3'd4, 5'b01000}, {3'd3, 5'b00110}, {3'd4, 5'b01001},
    {3'd4, 5'b01101}, {3'd4, 5'b00011},
    {3'd5, 5'b11111}, {3'd5, 5'b11110}, {3'd5, 5'b11100}, {3'd5, 5'b11000},
    {3'd5, 5'b10000}, {3'd5, 5'b00000}, {3'd5, 5'b00001}, {3'd5, 5'b00011},
    {3'd5, 5'b00111}, {3'd5, 5'b01111}
  };

  // Classify an ASCII character and fetch its code.
  function automatic code_entry_t code_lookup(input logic [7:0] ch);
    code_entry_t ent;
    logic [5:0]  idx;
    ent = '0;
    idx = '0;
    if (ch inside {[8'h41:8'h5A]}) begin
      idx = 6'(ch - 8'h41);
      ent.known = 1'b1;
    end else if (ch inside {[8'h61:8'h7A]}) begin
      idx = 6'(ch - 8'h61);
      ent.known = 1'b1;
    end else if (ch inside {[8'h30:8'h39]}) begin
      idx = 6'(ch - 8'h30) + 6'd26;
      ent.known = 1'b1;
    end
    if (ent.known) begin
      {ent.sym_count, ent.dash_mask} = CODE_ROM[idx];
    end
    return ent;
  endfunction

endpackage

// ===== hw/rtl/morse_character_keyer.sv =====
// A letter or digit of n symbols yields 2n+1 segments (3 to 11), one per cycle while the
// sink is ready; any other character yields 2 segments. Characters follow each other
// without a gap when the next one is already queued. The rate is set by the sequencer,
// which issues one segment per cycle to the output register while that register is free.
// Synchronous active-high reset empties the queue and idles the sequencer.
// ---------------------------------------------------------------------------
// Morse character keyer
// Turns ASCII characters into runs of Morse keying segments.
// ---------------------------------------------------------------------------
`include "morse_character_keyer_defines.svh"

module morse_character_keyer #(
  parameter int QUEUE_DEPTH = mck_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_code
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [0] key_on, [2:1] duration_units, [7:3] zero
  output logic       m_tlast    // last
);

  mck_pkg::queue_status_t q_status;
  mck_pkg::code_entry_t   q_push_data;
  mck_pkg::code_entry_t   q_pop_data;
  mck_pkg::back_status_t  b_status;
  logic                   q_push;
  logic                   q_pop;

  // Front end: accept and classify.
  mck_front u_front (
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .q_status    (q_status),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  // Queue between the two halves.
  mck_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .status    (q_status)
  );

  // Back end: segment sequencer.
  mck_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .q_data   (q_pop_data),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .status   (b_status)
  );

  // The front never pushes into a full queue, and the back never pops an empty one.
  `MCK_ASSERT_IMP(a_no_overflow, clk, rst, q_push, !q_status.full)
  `MCK_ASSERT_IMP(a_no_underflow, clk, rst, q_pop, !q_status.empty)
  // The step counter stays within the longest run of eleven segments.
  `MCK_ASSERT_IMP(a_step_range, clk, rst, b_status.busy, b_status.step <= 4'd10)
  // A popped code always starts a fresh run.
  `MCK_ASSERT_NEXT(a_pop_starts, clk, rst, q_pop, b_status.busy && b_status.step == 4'd0)

endmodule

// ===== hw/rtl/mck_front.sv =====
// ---------------------------------------------------------------------------
// Morse keyer front end
// Accepts characters, classifies them and pushes the code into the queue.
// ---------------------------------------------------------------------------
module mck_front (
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] char_code
  input  mck_pkg::queue_status_t q_status,
  output logic                  q_push,
  output mck_pkg::code_entry_t  q_push_data
);

  // A word is taken whenever the queue has room.
  assign s_tready    = !q_status.full;
  assign q_push      = s_tvalid && !q_status.full;
  assign q_push_data = mck_pkg::code_lookup(s_tdata);

endmodule

// ===== hw/rtl/mck_queue.sv =====
// ---------------------------------------------------------------------------
// Morse keyer code queue
// Small register FIFO between the front end and the segment sequencer.
// ---------------------------------------------------------------------------
module mck_queue #(
  parameter int DEPTH = mck_pkg::QUEUE_DEPTH  // at least 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  mck_pkg::code_entry_t   push_data,
  input  logic                   pop,
  output mck_pkg::code_entry_t   pop_data,
  output mck_pkg::queue_status_t status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  mck_pkg::code_entry_t entries [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;

  // Pointer advance with wrap at the depth.
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign status.empty = (count == '0);
  assign status.full  = (count == CNT_W'(DEPTH));
  assign pop_data     = entries[head];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= ptr_inc(tail);
      end
      if (pop) begin
        head <= ptr_inc(head);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/mck_back.sv =====
// ---------------------------------------------------------------------------
// Morse keyer segment sequencer
// Pops classified codes and issues one keying segment per cycle unless the output stalls.
// ---------------------------------------------------------------------------
module mck_back (
  input  logic                  clk,
  input  logic                  rst,
  input  mck_pkg::queue_status_t q_status,
  input  mck_pkg::code_entry_t  q_data,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // [0] key_on, [2:1] duration_units
  output logic                  m_tlast,   // last
  output mck_pkg::back_status_t status
);

  mck_pkg::code_entry_t cur;
  logic       busy;
  logic [3:0] step;
  logic       out_free;
  logic       seg_key;
  logic [1:0] seg_dur;
  logic       seg_last;

  assign out_free = !m_tvalid || m_tready;

  // Segment for the current step: gap/symbol pairs, then the closing space; two spaces if unknown.
  always_comb begin
    seg_key  = 1'b0;
    seg_dur  = mck_pkg::SPACE_UNITS;
    seg_last = 1'b0;
    if (!cur.known) begin
      seg_last = (step != 4'd0);
    end else if (step == {cur.sym_count, 1'b0}) begin
      seg_last = 1'b1;
    end else if (!step[0]) begin
      seg_dur = mck_pkg::GAP_UNITS;
    end else begin
      seg_key = 1'b1;
      seg_dur = cur.dash_mask[step[3:1]] ? mck_pkg::DASH_UNITS : mck_pkg::DOT_UNITS;
    end
  end

  // Take the next code when idle, or right behind the final segment.
  assign q_pop = !q_status.empty && (!busy || (out_free && seg_last));

  assign status.busy = busy;
  assign status.step = step;

  // Sequencer control and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_free) begin
        m_tvalid <= busy;
      end
      if (q_pop) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy && out_free) begin
        if (seg_last) begin
          busy <= 1'b0;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (busy && out_free) begin
      m_tdata <= {5'b0, seg_dur, seg_key};
      m_tlast <= seg_last;
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// ---------------------------------------------------------------------------
// Morse character keyer testbench
// Sends ASCII characters into the keyer and checks every keying segment
// against an independent table-driven prediction. A directed pass covers the
// table extremes and unknown characters, then random traffic runs under
// several source-idle and sink-stall settings.
// ---------------------------------------------------------------------------
module tb_top;

  localparam logic KEY_OFF = 1'b0;
  localparam logic KEY_ON  = 1'b1;
  localparam int   WATCHDOG_LIMIT = 2000;
  localparam int   DRAIN_CYCLES   = 20;
  localparam int   RANDOM_CHARS   = 110;

  // One keying segment as it leaves the block.
  typedef struct packed {
    logic       key_on;
    logic [1:0] units;
    logic       last;
  } segment_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] char_code
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [0] key_on, [2:1] duration_units, [7:3] zero
  logic       m_tlast;

  logic [7:0] char_q [$];
  segment_t   segment_q [$];
  int         src_idle_pct = 0;
  int         sink_stall_pct = 0;
  int         mismatches = 0;
  int         quiet_cycles = 0;

  // Dot and dash text for a..z, then 0..9.
  string morse_text [36] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
    ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
    "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--..",
    "-----", ".----", "..---", "...--", "....-",
    ".....", "-....", "--...", "---..", "----."
  };

  morse_character_keyer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Append the segments that one character should produce.
  function automatic void predict_keying(input logic [7:0] ch);
    int       idx;
    string    code;
    segment_t seg;
    idx = -1;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      idx = int'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      idx = int'(ch - 8'h61);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      idx = 26 + int'(ch - 8'h30);
    end
    if (idx < 0) begin
      // Characters without a code send two silent spaces.
      seg = '{KEY_OFF, mck_pkg::SPACE_UNITS, 1'b0};
      segment_q.push_back(seg);
      seg.last = 1'b1;
      segment_q.push_back(seg);
    end else begin
      code = morse_text[idx];
      for (int i = 0; i < code.len(); i++) begin
        seg = '{KEY_OFF, mck_pkg::GAP_UNITS, 1'b0};
        segment_q.push_back(seg);
        seg = '{KEY_ON, (code[i] == "-") ? mck_pkg::DASH_UNITS : mck_pkg::DOT_UNITS,
                1'b0};
        segment_q.push_back(seg);
      end
      seg = '{KEY_OFF, mck_pkg::SPACE_UNITS, 1'b1};
      segment_q.push_back(seg);
    end
  endfunction

  task automatic note_mismatch(input string what, input segment_t want,
                               input logic [7:0] got_data, input logic got_last);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected key %0b units %0d last %0b, got tdata %h last %0b",
               what, want.key_on, want.units, want.last, got_data, got_last);
    end
  endtask

  // Mostly letters and digits, the rest any byte at all.
  function automatic logic [7:0] random_char();
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) begin
      return 8'h61 + 8'($urandom_range(25));
    end else if (pick < 55) begin
      return 8'h41 + 8'($urandom_range(25));
    end else if (pick < 80) begin
      return 8'h30 + 8'($urandom_range(9));
    end
    return 8'($urandom_range(255));
  endfunction

  // Wait at the falling edge until every character is taken and every
  // segment has come back.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (char_q.size() != 0 || s_tvalid || segment_q.size() != 0);
  endtask

  task automatic run_random_phase(input int src_pct, input int sink_pct);
    @(negedge clk);
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    for (int i = 0; i < RANDOM_CHARS; i++) begin
      char_q.push_back(random_char());
    end
    wait_drained();
  endtask

  // Source side: offer the next pending character, or idle at random.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (char_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        s_tdata  <= char_q.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Sink side: stall at random.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Predict on each accepted character, check each accepted segment.
  always @(posedge clk) begin
    segment_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_keying(s_tdata);
      end
      if (m_tvalid && m_tready) begin
        if (segment_q.size() == 0) begin
          note_mismatch("unexpected segment", '0, m_tdata, m_tlast);
        end else begin
          want = segment_q.pop_front();
          if (m_tdata !== {5'b0, want.units, want.key_on} || m_tlast !== want.last) begin
            note_mismatch("segment mismatch", want, m_tdata, m_tlast);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no word moving on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("morse_character_keyer: mismatch");
      $finish;
    end
  end

  // Reset, then the directed pass and the random phases.
  initial begin
    logic [7:0] corner_chars [$];
    // Letter and digit ends, five-symbol digits, neighbors of every range,
    // space, control and high codes.
    corner_chars = '{8'h41, 8'h5A, 8'h61, 8'h7A, 8'h30, 8'h39, 8'h35, 8'h45,
                     8'h54, 8'h51, 8'h79, 8'h31, 8'h40, 8'h5B, 8'h60, 8'h7B,
                     8'h2F, 8'h3A, 8'h20, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'hC1};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    foreach (corner_chars[i]) begin
      char_q.push_back(corner_chars[i]);
    end
    wait_drained();

    run_random_phase(0, 0);
    run_random_phase(86, 0);
    run_random_phase(0, 86);
    run_random_phase(23, 23);

    // Catch any stray segment after the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && segment_q.size() == 0) begin
      $display("morse_character_keyer: match");
    end else begin
      $display("morse_character_keyer: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mck_pkg.sv
hw/rtl/mck_front.sv
hw/rtl/mck_queue.sv
hw/rtl/mck_back.sv
hw/rtl/morse_character_keyer.sv
bench/tb_top.sv
